>>> hw/rtl/wcmm_pkg.sv
// Shared types, constants and codes of the waveform column min/max reducer.
`timescale 1ns / 1ps
`default_nettype none
package wcmm_pkg;
  localparam int BIN_DEPTH_DEF = 256;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_FRAMES = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_FRAME = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPAN_FRAMES = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_WIDTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FRAMES_PER_BIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BIN_COUNT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BIN_DOMAIN = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SUMMARY_READY = 3'd7;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_PENDING = 2'd2;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_COLUMN = 1'b1;
endpackage
`default_nettype wire

>>> hw/rtl/waveform_column_min_max.sv
// Top level of the waveform column min/max reducer.
//
// Items enter on start/in_* and are accepted when start is high and busy is
// low. A bin write (command 0) stores one table entry at its accepting edge,
// gives no result and leaves busy low. A column request (command 1) gives
// exactly one result, shown on out_* for one cycle with out_valid high.
// Invalid or pending requests go from the check state straight to the done
// state. A valid column first divides the span by the width on a shared
// radix-2 divider, then runs two divisions for its bin range, then walks its
// N bins through the table at one bin per cycle, with N from 1 to BIN_DEPTH
// (256 by default). One item is worked on at a time; busy is high until the
// result shows. The result is not held: the receiver must take it in its
// cycle. Configuration is written through cfg_we/cfg_index/cfg_data; the user
// must write it only while the block is idle, as the block does not enforce
// it. Reset clears the registers and the column cursor; the bin table is not
// cleared and must be written before it is read. Table entries sit in two
// 1-read 1-write memories with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module waveform_column_min_max #(
  parameter int BIN_DEPTH = wcmm_pkg::BIN_DEPTH_DEF
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             start,
  output logic                            busy,
  input  wire                             in_command,
  input  wire  [7:0]                      in_bin_index,
  input  wire  signed [15:0]              in_bin_min,
  input  wire  signed [15:0]              in_bin_max,
  output logic                            out_valid,
  output logic [1:0]                      out_status,
  output logic [7:0]                      out_column_index,
  output logic signed [15:0]              out_column_min,
  output logic signed [15:0]              out_column_max,
  output logic                            out_last,
  input  wire                             cfg_we,
  input  wire  [wcmm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [wcmm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import wcmm_pkg::*;

  localparam int AW = (BIN_DEPTH > 1) ? $clog2(BIN_DEPTH) : 1;
  localparam int CW = $clog2(BIN_DEPTH + 1);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_CHECK = 11'b00000000010,
    S_STEP  = 11'b00000000100,
    S_F1    = 11'b00000001000,
    S_MAP0  = 11'b00000010000,
    S_DIV0  = 11'b00000100000,
    S_DIV1  = 11'b00001000000,
    S_CLAMP = 11'b00010000000,
    S_RD    = 11'b00100000000,
    S_WALK  = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [31:0] source_frames_r, start_frame_r, span_frames_r, fpb_r, domain_r;
  logic [7:0]  pixel_width_r;
  logic [8:0]  bin_count_r;
  logic        summary_ready_r;

  logic signed [15:0] min_mem [BIN_DEPTH];
  logic signed [15:0] max_mem [BIN_DEPTH];
  logic signed [15:0] rd_min_r, rd_max_r;
  logic [AW-1:0]      rd_addr;
  logic               rd_en;

  logic [7:0]  next_column_r, col_r;
  logic [32:0] frame_cursor_r;
  logic [7:0]  spread_rem_r;
  logic [31:0] step_r, frame0_r, frame1_r;
  logic [7:0]  rem_add_r;
  logic [CW-1:0] nb_r;

  // Shared restoring divider: 64-bit dividend, 32-bit divisor.
  logic [63:0] dv_q_r;
  logic [32:0] dv_rem_r;
  logic [31:0] dv_den_r;
  logic [6:0]  dv_cnt_r;
  logic        dv_busy_r;
  logic [32:0] dv_trial;
  logic [33:0] dv_sub;
  logic        dv_restart;

  logic [63:0] bin0_r, num_r;
  logic [AW-1:0] b_r;
  logic [CW-1:0] bend_r;
  logic signed [15:0] mn_r, mx_r;
  logic        first_r;

  logic accept;
  assign accept = start && !busy;
  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      source_frames_r <= '0; start_frame_r <= '0; span_frames_r <= '0;
      pixel_width_r <= '0; fpb_r <= '0; bin_count_r <= '0; domain_r <= '0;
      summary_ready_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SOURCE_FRAMES:  source_frames_r <= cfg_data;
        REG_START_FRAME:    start_frame_r <= cfg_data;
        REG_SPAN_FRAMES:    span_frames_r <= cfg_data;
        REG_PIXEL_WIDTH:    pixel_width_r <= cfg_data[7:0];
        REG_FRAMES_PER_BIN: fpb_r <= cfg_data;
        REG_BIN_COUNT:      bin_count_r <= cfg_data[8:0];
        REG_BIN_DOMAIN:     domain_r <= cfg_data;
        REG_SUMMARY_READY:  summary_ready_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_command == CMD_WRITE && 32'(in_bin_index) < BIN_DEPTH) begin
      min_mem[AW'(in_bin_index)] <= in_bin_min;
      max_mem[AW'(in_bin_index)] <= in_bin_max;
    end
    if (rd_en) begin
      rd_min_r <= min_mem[rd_addr];
      rd_max_r <= max_mem[rd_addr];
    end
  end

  assign dv_trial = {dv_rem_r[31:0], dv_q_r[63]};
  assign dv_sub = {1'b0, dv_trial} - {2'b00, dv_den_r};
  assign dv_restart = (state_r == S_DIV0) && dv_busy_r && (dv_cnt_r == 7'd0);

  // Request validity checks and bin count saturation.
  logic [CW-1:0] nb_sat;
  logic          req_bad;
  assign nb_sat = (32'(bin_count_r) > BIN_DEPTH) ? CW'(BIN_DEPTH) : CW'(bin_count_r);
  assign req_bad = (pixel_width_r == 8'd0) || (span_frames_r == 32'd0) ||
                   (start_frame_r >= source_frames_r) ||
                   (span_frames_r > source_frames_r - start_frame_r);

  logic [31:0] dom;
  assign dom = (domain_r != 32'd0) ? domain_r : source_frames_r;

  logic [8:0] rsum;
  assign rsum = {1'b0, spread_rem_r} + {1'b0, rem_add_r};
  logic [32:0] cur_step;
  assign cur_step = frame_cursor_r + {1'b0, step_r};

  logic [63:0] bin1_c, bin0_c;
  assign bin0_c = (bin0_r >= 64'(nb_r)) ? 64'(nb_r) - 64'd1 : bin0_r;
  assign bin1_c = dv_q_r;

  always_comb begin
    state_nxt = state_r;
    rd_en = 1'b0;
    rd_addr = b_r;
    case (state_r)
      S_IDLE:  if (accept && in_command == CMD_COLUMN) state_nxt = S_CHECK;
      S_CHECK: state_nxt = (req_bad || !summary_ready_r || nb_sat == '0) ? S_DONE : S_STEP;
      S_STEP:  if (dv_busy_r && dv_cnt_r == 7'd0) state_nxt = S_F1;
      S_F1:    state_nxt = S_MAP0;
      S_MAP0:  state_nxt = S_DIV0;
      S_DIV0:  if (dv_busy_r && dv_cnt_r == 7'd0) state_nxt = S_DIV1;
      S_DIV1:  if (dv_busy_r && dv_cnt_r == 7'd0) state_nxt = S_CLAMP;
      S_CLAMP: state_nxt = S_RD;
      S_RD: begin
        rd_en = 1'b1;
        state_nxt = (CW'(b_r) + CW'(1) >= bend_r) ? S_DONE : S_WALK;
      end
      S_WALK: begin
        rd_en = 1'b1;
        if (CW'(b_r) + CW'(1) >= bend_r) state_nxt = S_DONE;
      end
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  logic [1:0] err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      next_column_r <= '0;
      frame_cursor_r <= '0;
      spread_rem_r <= '0;
      dv_busy_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid <= (state_r == S_DONE);
      if (dv_busy_r && !dv_restart) begin
        dv_q_r <= {dv_q_r[62:0], !dv_sub[33]};
        dv_rem_r <= dv_sub[33] ? dv_trial : dv_sub[32:0];
        dv_cnt_r <= dv_cnt_r - 7'd1;
        if (dv_cnt_r == 7'd0) dv_busy_r <= 1'b0;
      end
      case (state_r)
        S_CHECK: begin
          nb_r <= nb_sat;
          if (req_bad) err_r <= ST_INVALID;
          else if (!summary_ready_r || nb_sat == '0) err_r <= ST_PENDING;
          else begin
            err_r <= ST_OK;
            if (next_column_r >= pixel_width_r || next_column_r == 8'd0) begin
              col_r <= 8'd0;
              frame_cursor_r <= {1'b0, start_frame_r};
              spread_rem_r <= 8'd0;
            end else col_r <= next_column_r;
            dv_q_r <= {span_frames_r, 32'd0};
            dv_rem_r <= '0;
            dv_den_r <= {24'd0, pixel_width_r};
            dv_cnt_r <= 7'd31;
            dv_busy_r <= 1'b1;
          end
          if (req_bad || !summary_ready_r || nb_sat == '0) next_column_r <= 8'd0;
        end
        S_STEP: if (dv_busy_r && dv_cnt_r == 7'd0) begin
          step_r <= {dv_q_r[30:0], !dv_sub[33]};
          rem_add_r <= dv_sub[33] ? dv_trial[7:0] : dv_sub[7:0];
        end
        S_F1: begin
          frame0_r <= frame_cursor_r[31:0];
          if (rsum >= {1'b0, pixel_width_r}) begin
            spread_rem_r <= 8'(rsum - {1'b0, pixel_width_r});
            frame_cursor_r <= cur_step + 33'd1;
          end else begin
            spread_rem_r <= rsum[7:0];
            frame_cursor_r <= cur_step;
          end
        end
        S_MAP0: begin
          // One past the last frame lies beyond any source, so it clamps to the source end.
          if (frame_cursor_r[31:0] <= frame0_r)
            frame1_r <= (frame0_r == 32'hFFFF_FFFF) ? source_frames_r : frame0_r + 32'd1;
          else frame1_r <= frame_cursor_r[31:0];
          dv_rem_r <= '0;
          dv_cnt_r <= 7'd63;
          dv_busy_r <= 1'b1;
          if (fpb_r != 32'd0) begin
            dv_q_r <= {32'd0, frame0_r};
            dv_den_r <= fpb_r;
          end else begin
            dv_q_r <= 64'(frame0_r) * 64'(nb_r);
            dv_den_r <= dom;
          end
        end
        S_DIV0: begin
          if (dv_busy_r && dv_cnt_r == 7'd0) begin
            bin0_r <= {dv_q_r[62:0], !dv_sub[33]};
            dv_rem_r <= '0;
            dv_cnt_r <= 7'd63;
            dv_busy_r <= 1'b1;
            dv_q_r <= num_r;
          end else begin
            if (frame1_r > source_frames_r) frame1_r <= source_frames_r;
            if (fpb_r != 32'd0)
              num_r <= 64'(frame1_r > source_frames_r ? source_frames_r : frame1_r)
                       + 64'(fpb_r) - 64'd1;
            else
              num_r <= 64'(frame1_r > source_frames_r ? source_frames_r : frame1_r)
                       * 64'(nb_r) + 64'(dom) - 64'd1;
          end
        end
        S_CLAMP: begin
          b_r <= AW'(bin0_c);
          if (bin1_c <= bin0_c) bend_r <= CW'(bin0_c + 64'd1);
          else if (bin1_c > 64'(nb_r)) bend_r <= nb_r;
          else bend_r <= CW'(bin1_c);
          first_r <= 1'b1;
        end
        S_RD: b_r <= b_r + AW'(1);
        S_WALK: begin
          b_r <= b_r + AW'(1);
          first_r <= 1'b0;
          if (first_r || rd_min_r < mn_r) mn_r <= rd_min_r;
          if (first_r || rd_max_r > mx_r) mx_r <= rd_max_r;
        end
        S_DONE: begin
          out_status <= err_r;
          if (err_r != ST_OK) begin
            out_column_index <= '0;
            out_column_min <= '0;
            out_column_max <= '0;
            out_last <= 1'b1;
          end else begin
            out_column_index <= col_r;
            out_column_min <= (rd_min_r < mn_r || first_r) ? rd_min_r : mn_r;
            out_column_max <= (rd_max_r > mx_r || first_r) ? rd_max_r : mx_r;
            if ({1'b0, col_r} + 9'd1 >= {1'b0, pixel_width_r}) begin
              out_last <= 1'b1;
              next_column_r <= 8'd0;
            end else begin
              out_last <= 1'b0;
              next_column_r <= col_r + 8'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/wcmm_checker.sv
// Port-level assertions for the waveform column min/max reducer.
`timescale 1ns / 1ps
`default_nettype none
module wcmm_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       start,
  input wire       busy,
  input wire       in_command,
  input wire       out_valid,
  input wire [1:0] out_status,
  input wire       out_last
);
  import wcmm_pkg::*;

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_last) else $error("error without last");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3) else $error("bad status");
  a_col_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_command == CMD_COLUMN |=> busy) else $error("column not taken");
  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_command == CMD_WRITE |=> !busy) else $error("write stalled");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("double result");
endmodule

bind waveform_column_min_max wcmm_checker u_wcmm_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_command(in_command),
  .out_valid(out_valid), .out_status(out_status), .out_last(out_last)
);
`default_nettype wire
